// ===== rtl/core/fsse_pkg.sv =====
package fsse_pkg;

    // field widths
    localparam int TIME_W  = 40;
    localparam int ACC_W   = 48;
    localparam int PROC_W  = 16;
    localparam int DUE_W   = 32;
    localparam int JOBS_W  = 11;
    localparam int MCNT_W  = 6;

    localparam int DEF_MAX_MACHINES = 32;
    localparam int DEF_MAX_JOBS     = 1024;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCKING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MACHINES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_JOBS     = 2'd2;

    localparam logic CMD_OP    = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef logic [TIME_W-1:0] t_time;
    typedef logic [ACC_W-1:0]  t_acc;

    localparam t_time TIME_MAX = '1;
    localparam t_acc  ACC_MAX  = '1;

    // machine-time store control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } t_store_ctl;

    function automatic t_time sat_time(input t_time a, input t_time b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    function automatic t_acc sat_acc(input t_acc a, input t_time b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + (ACC_W + 1)'(b);
        return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
    endfunction

    function automatic t_time pos_diff(input t_time a, input t_time b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

// ===== rtl/core/fsse_time_store.sv =====
module fsse_time_store #(
    parameter int DEPTH = fsse_pkg::DEF_MAX_MACHINES,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fsse_pkg::t_store_ctl i_ctl,
    input  logic [AW-1:0]        i_rd_addr0,
    input  logic [AW-1:0]        i_rd_addr1,
    input  logic [AW-1:0]        i_wr_addr,
    input  fsse_pkg::t_time      i_wr_data,
    output fsse_pkg::t_time      o_rd_data0,
    output fsse_pkg::t_time      o_rd_data1
);
    import fsse_pkg::*;

    t_time            r_mem [DEPTH];
    t_time            r_q0;
    t_time            r_q1;
    t_time            r_wdata;
    logic [DEPTH-1:0] r_valid;
    logic             r_hit0;
    logic             r_hit1;
    logic             r_live0;
    logic             r_live1;

    // 1R1R1W array, read-before-write
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_q0 <= r_mem[i_rd_addr0];
            r_q1 <= r_mem[i_rd_addr1];
        end
    end

    // bypass of a same-cycle write or clear
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_hit0  <= i_ctl.wr_en && (i_wr_addr == i_rd_addr0);
            r_hit1  <= i_ctl.wr_en && (i_wr_addr == i_rd_addr1);
            r_live0 <= r_valid[i_rd_addr0] && !i_ctl.clr;
            r_live1 <= r_valid[i_rd_addr1] && !i_ctl.clr;
            r_wdata <= i_wr_data;
        end
    end

    // per-entry valid: unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.clr) begin
            r_valid <= '0;
        end else if (i_ctl.wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data0 = r_hit0 ? r_wdata : (r_live0 ? r_q0 : '0);
    assign o_rd_data1 = r_hit1 ? r_wdata : (r_live1 ? r_q1 : '0);

endmodule

// ===== rtl/core/flow_shop_schedule_evaluator_top.sv =====
// A job's result passes the stage 1, 2, 3 and result registers after its last operation is taken.
// Throughput: one request per cycle unless a held result stalls the input, limited by the
//   carry of the chain time through the recurrence and the machine-time memory write-back.
// Reset (synchronous, active low) empties the schedule, clears all totals and
//   loads blocking_mode=0, machine_count=1, job_count=1024; no clearing pass.
module flow_shop_schedule_evaluator_top #(
    parameter int MAX_MACHINES = fsse_pkg::DEF_MAX_MACHINES,
    parameter int MAX_JOBS     = fsse_pkg::DEF_MAX_JOBS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [fsse_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fsse_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_cmd,
    input  logic [fsse_pkg::PROC_W-1:0]      i_proc_time,
    input  logic [fsse_pkg::DUE_W-1:0]       i_due_date,
    input  logic                             i_has_due_date,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [fsse_pkg::TIME_W-1:0]      o_job_completion,
    output logic [fsse_pkg::TIME_W-1:0]      o_job_idle,
    output logic [fsse_pkg::ACC_W-1:0]       o_total_idle,
    output logic [fsse_pkg::ACC_W-1:0]       o_completion_sum,
    output logic [fsse_pkg::ACC_W-1:0]       o_tardy_total,
    output logic [fsse_pkg::ACC_W-1:0]       o_early_total,
    output logic [fsse_pkg::JOBS_W-1:0]      o_jobs_done
);
    import fsse_pkg::*;

    // machine index width, machine count width, job tally width
    localparam int MW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int CW = $clog2(MAX_MACHINES + 1);
    localparam int XW = (CW > MCNT_W) ? CW : MCNT_W;
    localparam int TW = $clog2(MAX_JOBS + 1);
    localparam int NW = (TW > JOBS_W) ? TW : JOBS_W;
    // flow increment product and its saturating sum
    localparam int PW = TW + TIME_W;
    localparam int SW = ((PW > ACC_W) ? PW : ACC_W) + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic              r_blocking;
    logic [MCNT_W-1:0] r_mcount;
    logic [JOBS_W-1:0] r_jcount;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocking <= 1'b0;
            r_mcount   <= MCNT_W'(1);
            r_jcount   <= JOBS_W'(1024);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BLOCKING: r_blocking <= i_cfg_data[0];
                REG_MACHINES: r_mcount   <= i_cfg_data[MCNT_W-1:0];
                REG_JOBS:     r_jcount   <= i_cfg_data[JOBS_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Global advance: every stage moves unless a shown result is held.
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic w_en;
    logic w_in_acc;
    logic w_in_op;
    logic w_in_clr;

    assign w_en       = !(r_out_valid && i_out_stall);
    assign o_in_stall = !(w_en && i_rst_n);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_in_op    = w_in_acc && (i_cmd == CMD_OP);
    assign w_in_clr   = w_in_acc && (i_cmd == CMD_CLEAR);

    // ------------------------------------------------------------------
    // Stage 0: pick the machine, issue the memory reads
    // ------------------------------------------------------------------
    logic [MW-1:0] r_op_index;
    logic [XW-1:0] w_mc_ext;
    logic [XW-1:0] w_mclamp;
    logic [MW-1:0] w_last;
    logic [MW-1:0] w_k;
    logic [MW-1:0] w_rd1;
    logic          w_at_last;

    assign w_mc_ext = XW'(r_mcount);

    always_comb begin
        if (w_mc_ext == '0) begin
            w_mclamp = XW'(1);
        end else if (w_mc_ext > XW'(MAX_MACHINES)) begin
            w_mclamp = XW'(MAX_MACHINES);
        end else begin
            w_mclamp = w_mc_ext;
        end
    end

    assign w_last    = MW'(w_mclamp - XW'(1));
    // an index past a shrunk machine count is taken as the last machine
    assign w_k       = (r_op_index > w_last) ? w_last : r_op_index;
    assign w_at_last = (w_k == w_last);
    // next machine, only looked at when this one is not the last
    assign w_rd1     = w_at_last ? w_k : (w_k + MW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_index <= '0;
        end else if (w_in_clr) begin
            r_op_index <= '0;
        end else if (w_in_op) begin
            r_op_index <= w_at_last ? '0 : (w_k + MW'(1));
        end
    end

    // stage 1 registers
    logic                r_s1_valid;
    logic                r_s1_clr;
    logic                r_s1_first;
    logic                r_s1_last;
    logic                r_s1_single;
    logic [MW-1:0]       r_s1_k;
    logic [PROC_W-1:0]   r_s1_p;
    logic [DUE_W-1:0]    r_s1_due;
    logic                r_s1_has_due;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_in_acc) begin
            r_s1_clr     <= (i_cmd == CMD_CLEAR);
            r_s1_first   <= (w_k == '0);
            r_s1_last    <= w_at_last;
            r_s1_single  <= (w_last == '0);
            r_s1_k       <= w_k;
            r_s1_p       <= i_proc_time;
            r_s1_due     <= i_due_date;
            r_s1_has_due <= i_has_due_date;
        end
    end

    // ------------------------------------------------------------------
    // Machine release times: one memory, read in stage 0, written in
    // stage 1. The store bypasses a write or clear landing in the
    // same cycle as a read.
    // ------------------------------------------------------------------
    t_store_ctl w_ctl;
    t_time      w_q0;     // this machine's release time
    t_time      w_q1;     // next machine's release time
    t_time      w_t;
    t_time      w_idle;
    logic       w_s1_op;
    logic       w_s1_res;
    logic       w_s1_clear;

    assign w_s1_op    = r_s1_valid && w_en && !r_s1_clr;
    assign w_s1_res   = w_s1_op && r_s1_last;
    assign w_s1_clear = r_s1_valid && w_en && r_s1_clr;

    assign w_ctl.rd_en = w_in_op;
    assign w_ctl.wr_en = w_s1_op;
    assign w_ctl.clr   = w_s1_clear;

    fsse_time_store #(
        .DEPTH (MAX_MACHINES),
        .AW    (MW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_rd_addr0 (w_k),
        .i_rd_addr1 (w_rd1),
        .i_wr_addr  (r_s1_k),
        .i_wr_data  (w_t),
        .o_rd_data0 (w_q0),
        .o_rd_data1 (w_q1)
    );

    // ------------------------------------------------------------------
    // Stage 1: recurrence. Chain time is this job's time on the
    // previous machine; it starts from zero on machine 0.
    // ------------------------------------------------------------------
    t_time r_chain;
    t_time w_chain;
    t_time w_p;
    t_time w_ch_p;
    t_time w_pr_p;
    t_time w_start;

    assign w_chain = r_s1_first ? '0 : r_chain;
    assign w_p     = TIME_W'(r_s1_p);
    assign w_ch_p  = sat_time(w_chain, w_p);
    assign w_pr_p  = sat_time(w_q0, w_p);
    assign w_start = (w_chain > w_q0) ? w_chain : w_q0;

    always_comb begin
        // unlimited buffers: max-plus
        w_t    = sat_time(w_start, w_p);
        w_idle = w_start - w_q0;
        if (r_blocking) begin
            if (r_s1_first) begin
                // first machine: hold the job until the next machine frees up
                if (r_s1_single || (w_pr_p > w_q1)) begin
                    w_t    = w_pr_p;
                    w_idle = '0;
                end else begin
                    w_t    = w_q1;
                    w_idle = w_q1 - w_pr_p;
                end
            end else if (!r_s1_last) begin
                if (w_ch_p > w_q1) begin
                    w_t    = w_ch_p;
                    w_idle = pos_diff(w_chain, w_q0);
                end else begin
                    w_t    = w_q1;
                    w_idle = pos_diff(w_q1, w_pr_p);
                end
            end else begin
                // last machine never blocks
                w_t    = w_ch_p;
                w_idle = pos_diff(w_chain, w_q0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_op) begin
            r_chain <= w_t;
        end
    end

    // job tally and flow-time weight
    logic [TW-1:0] r_tally;
    logic [TW-1:0] w_tally_next;
    logic [NW-1:0] w_jc_ext;
    logic [TW-1:0] w_n;
    logic [TW-1:0] w_weight;

    assign w_jc_ext = NW'(r_jcount);

    always_comb begin
        if (w_jc_ext == '0) begin
            w_n = TW'(1);
        end else if (w_jc_ext > NW'(MAX_JOBS)) begin
            w_n = TW'(MAX_JOBS);
        end else begin
            w_n = TW'(w_jc_ext);
        end
    end

    // jobs past job_count weigh nothing
    assign w_weight     = (w_n > r_tally) ? (w_n - r_tally) : '0;
    assign w_tally_next = (r_tally < TW'(MAX_JOBS)) ? (r_tally + TW'(1)) : r_tally;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= '0;
        end else if (w_s1_clear) begin
            r_tally <= '0;
        end else if (w_s1_res) begin
            r_tally <= w_tally_next;
        end
    end

    // stage 2 registers
    logic             r_s2_valid;
    logic             r_s2_clr;
    logic             r_s2_first;
    logic             r_s2_res;
    t_time            r_s2_t;
    t_time            r_s2_old;
    t_time            r_s2_idle;
    logic [TW-1:0]    r_s2_weight;
    logic [TW-1:0]    r_s2_tally;
    logic [DUE_W-1:0] r_s2_due;
    logic             r_s2_has_due;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    // on the last machine the memory read of this machine is the old
    // last-machine time
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_clr     <= r_s1_clr;
            r_s2_first   <= r_s1_first;
            r_s2_res     <= r_s1_last;
            r_s2_t       <= w_t;
            r_s2_old     <= w_q0;
            r_s2_idle    <= w_idle;
            r_s2_weight  <= w_weight;
            r_s2_tally   <= w_tally_next;
            r_s2_due     <= r_s1_due;
            r_s2_has_due <= r_s1_has_due;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: idle totals, flow increment product, due-date terms
    // ------------------------------------------------------------------
    t_time r_jidle;
    t_acc  r_idle_acc;
    t_time w_jidle_new;
    t_acc  w_idle_new;
    t_time w_delta;
    t_time w_due_ext;
    logic  w_s2_op;
    logic  w_s2_clear;

    assign w_s2_op     = r_s2_valid && w_en && !r_s2_clr;
    assign w_s2_clear  = r_s2_valid && w_en && r_s2_clr;
    assign w_jidle_new = sat_time(r_s2_first ? '0 : r_jidle, r_s2_idle);
    assign w_idle_new  = sat_acc(r_idle_acc, r_s2_idle);
    assign w_delta     = pos_diff(r_s2_t, r_s2_old);
    assign w_due_ext   = TIME_W'(r_s2_due);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jidle    <= '0;
            r_idle_acc <= '0;
        end else if (w_s2_clear) begin
            r_jidle    <= '0;
            r_idle_acc <= '0;
        end else if (w_s2_op) begin
            r_jidle    <= w_jidle_new;
            r_idle_acc <= w_idle_new;
        end
    end

    // stage 3 registers
    logic          r_s3_valid;
    logic          r_s3_clr;
    logic          r_s3_res;
    t_time         r_s3_t;
    t_time         r_s3_jidle;
    t_acc          r_s3_idle;
    logic [PW-1:0] r_s3_prod;
    t_time         r_s3_tardy;
    t_time         r_s3_early;
    logic          r_s3_has_due;
    logic [TW-1:0] r_s3_tally;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_clr     <= r_s2_clr;
            r_s3_res     <= r_s2_res;
            r_s3_t       <= r_s2_t;
            r_s3_jidle   <= w_jidle_new;
            r_s3_idle    <= w_idle_new;
            r_s3_prod    <= PW'(r_s2_weight) * PW'(w_delta);
            r_s3_tardy   <= pos_diff(r_s2_t, w_due_ext);
            r_s3_early   <= pos_diff(w_due_ext, r_s2_t);
            r_s3_has_due <= r_s2_has_due;
            r_s3_tally   <= r_s2_tally;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: per-job totals, result register
    // ------------------------------------------------------------------
    t_acc          r_flow;
    t_acc          r_tardy;
    t_acc          r_early;
    logic [SW-1:0] w_flow_sum;
    t_acc          w_flow_new;
    t_acc          w_tardy_new;
    t_acc          w_early_new;
    logic          w_s3_res;
    logic          w_s3_clear;

    assign w_s3_res    = r_s3_valid && w_en && !r_s3_clr && r_s3_res;
    assign w_s3_clear  = r_s3_valid && w_en && r_s3_clr;
    assign w_flow_sum  = SW'(r_flow) + SW'(r_s3_prod);
    assign w_flow_new  = (w_flow_sum > SW'(ACC_MAX)) ? ACC_MAX : ACC_W'(w_flow_sum);
    // jobs without a due date leave tardiness and earliness alone
    assign w_tardy_new = r_s3_has_due ? sat_acc(r_tardy, r_s3_tardy) : r_tardy;
    assign w_early_new = r_s3_has_due ? sat_acc(r_early, r_s3_early) : r_early;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow  <= '0;
            r_tardy <= '0;
            r_early <= '0;
        end else if (w_s3_clear) begin
            r_flow  <= '0;
            r_tardy <= '0;
            r_early <= '0;
        end else if (w_s3_res) begin
            r_flow  <= w_flow_new;
            r_tardy <= w_tardy_new;
            r_early <= w_early_new;
        end
    end

    t_time             r_out_completion;
    t_time             r_out_jidle;
    t_acc              r_out_idle;
    t_acc              r_out_flow;
    t_acc              r_out_tardy;
    t_acc              r_out_early;
    logic [JOBS_W-1:0] r_out_jobs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_s3_valid && !r_s3_clr && r_s3_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s3_res) begin
            r_out_completion <= r_s3_t;
            r_out_jidle      <= r_s3_jidle;
            r_out_idle       <= r_s3_idle;
            r_out_flow       <= w_flow_new;
            r_out_tardy      <= w_tardy_new;
            r_out_early      <= w_early_new;
            r_out_jobs       <= JOBS_W'(r_s3_tally);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_job_completion  = r_out_completion;
    assign o_job_idle        = r_out_jidle;
    assign o_total_idle      = r_out_idle;
    assign o_completion_sum  = r_out_flow;
    assign o_tardy_total     = r_out_tardy;
    assign o_early_total     = r_out_early;
    assign o_jobs_done       = r_out_jobs;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_out_from_job_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_s3_valid && !r_s3_clr && r_s3_res))
        else $error("result shown without a finished job behind it");

    a_op_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && w_in_op && !w_at_last) |=> (r_op_index == ($past(w_k) + MW'(1))))
        else $error("operation index did not step to the next machine");

    a_tally_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && w_s1_op) |=> (r_tally >= $past(r_tally)))
        else $error("job tally went down without a clear");

endmodule

// ===== dv/schedule_checker.sv =====
`timescale 1ns / 1ps

module schedule_checker #(
    parameter int MAX_MACHINES = fsse_pkg::DEF_MAX_MACHINES,
    parameter int MAX_JOBS     = fsse_pkg::DEF_MAX_JOBS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fsse_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fsse_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic                             i_cmd,
    input  logic [fsse_pkg::PROC_W-1:0]      i_proc_time,
    input  logic [fsse_pkg::DUE_W-1:0]       i_due_date,
    input  logic                             i_has_due_date,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic [fsse_pkg::TIME_W-1:0]      i_job_completion,
    input  logic [fsse_pkg::TIME_W-1:0]      i_job_idle,
    input  logic [fsse_pkg::ACC_W-1:0]       i_total_idle,
    input  logic [fsse_pkg::ACC_W-1:0]       i_completion_sum,
    input  logic [fsse_pkg::ACC_W-1:0]       i_tardy_total,
    input  logic [fsse_pkg::ACC_W-1:0]       i_early_total,
    input  logic [fsse_pkg::JOBS_W-1:0]      i_jobs_done,
    output int                               o_fail_count,
    output int                               o_pending
);
    import fsse_pkg::*;

    localparam logic [63:0] TIME_TOP = (64'd1 << TIME_W) - 64'd1;
    localparam logic [63:0] ACC_TOP  = (64'd1 << ACC_W) - 64'd1;

    typedef struct {
        t_time             completion;
        t_time             job_idle;
        t_acc              idle_total;
        t_acc              flow_sum;
        t_acc              tardiness;
        t_acc              earliness;
        logic [JOBS_W-1:0] jobs;
    } t_job_result;

    // register copies
    logic              cfg_blocking;
    logic [MCNT_W-1:0] cfg_machines;
    logic [JOBS_W-1:0] cfg_jobs;

    // schedule state
    t_time mach_free [MAX_MACHINES];
    int    next_op;
    t_time chain_t;
    t_time idle_this_job;
    t_acc  idle_sum;
    t_acc  flow_sum;
    t_acc  tardy_sum;
    t_acc  early_sum;
    int    jobs_scheduled;

    t_job_result finished_jobs_q [$];
    t_job_result oldest;
    int          fail_total;
    int          checked_total;

    assign o_fail_count = fail_total;

    function automatic t_time clip_time(input logic [63:0] v);
        return (v > TIME_TOP) ? TIME_TOP[TIME_W-1:0] : v[TIME_W-1:0];
    endfunction

    function automatic t_acc clip_acc(input logic [63:0] v);
        return (v > ACC_TOP) ? ACC_TOP[ACC_W-1:0] : v[ACC_W-1:0];
    endfunction

    function automatic logic [63:0] minus0(input logic [63:0] a, input logic [63:0] b);
        return (a > b) ? a - b : 64'd0;
    endfunction

    function automatic void charge_idle(input logic [63:0] v);
        idle_this_job = clip_time(idle_this_job + v);
        idle_sum      = clip_acc(idle_sum + v);
    endfunction

    function automatic void clear_schedule();
        foreach (mach_free[i]) mach_free[i] = '0;
        next_op        = 0;
        chain_t        = '0;
        idle_this_job  = '0;
        idle_sum       = '0;
        flow_sum       = '0;
        tardy_sum      = '0;
        early_sum      = '0;
        jobs_scheduled = 0;
    endfunction

    // One request: advance the schedule, queue a result when a job completes.
    function automatic void schedule_op(input logic cmd, input logic [PROC_W-1:0] p,
                                        input logic [DUE_W-1:0] due, input logic has_due);
        int          m;
        int          last;
        int          k;
        int          n;
        t_time       prev;
        t_time       nxt;
        t_time       f;
        t_time       start;
        t_time       t;
        t_time       old_last;
        logic [63:0] weight;
        t_job_result r;
        if (cmd == CMD_CLEAR) begin
            clear_schedule();
            return;
        end
        m = int'(cfg_machines);
        if (m < 1) m = 1;
        if (m > MAX_MACHINES) m = MAX_MACHINES;
        last = m - 1;
        k = next_op;
        if (k > last) k = last;
        if (k == 0) begin
            chain_t       = '0;
            idle_this_job = '0;
        end
        prev     = mach_free[k];
        old_last = mach_free[last];

        if (!cfg_blocking) begin
            start = (chain_t > prev) ? chain_t : prev;
            charge_idle(start - prev);
            t = clip_time(start + p);
        end else if (k == 0) begin
            f = clip_time(prev + p);
            if (last == 0) begin
                t = f;
            end else begin
                nxt = mach_free[1];
                if (f > nxt) begin
                    t = f;
                end else begin
                    charge_idle(minus0(nxt, f));
                    t = nxt;
                end
            end
        end else if (k < last) begin
            f   = clip_time(chain_t + p);
            nxt = mach_free[k + 1];
            if (f > nxt) begin
                charge_idle(minus0(chain_t, prev));
                t = f;
            end else begin
                // job is held on this machine until the next one frees up
                charge_idle(minus0(nxt, clip_time(prev + p)));
                t = nxt;
            end
        end else begin
            charge_idle(minus0(chain_t, prev));
            t = clip_time(chain_t + p);
        end

        mach_free[k] = t;
        chain_t      = t;
        if (k < last) begin
            next_op = k + 1;
            return;
        end

        n = int'(cfg_jobs);
        if (n < 1) n = 1;
        if (n > MAX_JOBS) n = MAX_JOBS;
        weight   = (jobs_scheduled < n) ? 64'(n - jobs_scheduled) : 64'd0;
        flow_sum = clip_acc(flow_sum + weight * minus0(t, old_last));
        if (has_due) begin
            tardy_sum = clip_acc(tardy_sum + minus0(t, due));
            early_sum = clip_acc(early_sum + minus0(due, t));
        end
        if (jobs_scheduled < MAX_JOBS) jobs_scheduled++;

        r.completion = t;
        r.job_idle   = idle_this_job;
        r.idle_total = idle_sum;
        r.flow_sum   = flow_sum;
        r.tardiness  = tardy_sum;
        r.earliness  = early_sum;
        r.jobs       = JOBS_W'(jobs_scheduled);
        finished_jobs_q.insert(finished_jobs_q.size(), r);

        next_op       = 0;
        chain_t       = '0;
        idle_this_job = '0;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        // keep the log bounded if the block is badly broken
        if (fail_total < 100)
            $display("%0t job %0d %s: got %0h, want %0h", $realtime, checked_total, what,
                     got, want);
        fail_total++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_blocking = 1'b0;
            cfg_machines = MCNT_W'(1);
            cfg_jobs     = JOBS_W'(MAX_JOBS);
            clear_schedule();
            finished_jobs_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_BLOCKING: cfg_blocking = i_cfg_data[0];
                    REG_MACHINES: cfg_machines = i_cfg_data[MCNT_W-1:0];
                    REG_JOBS:     cfg_jobs     = i_cfg_data[JOBS_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                schedule_op(i_cmd, i_proc_time, i_due_date, i_has_due_date);
            if (i_out_valid && !i_out_stall) begin
                if (finished_jobs_q.size() == 0) begin
                    report_mismatch("result with no job pending", i_job_completion, '0);
                end else begin
                    oldest = finished_jobs_q.pop_front();
                    check_field("job_completion", i_job_completion, oldest.completion);
                    check_field("job_idle", i_job_idle, oldest.job_idle);
                    check_field("total_idle", i_total_idle, oldest.idle_total);
                    check_field("completion_sum", i_completion_sum, oldest.flow_sum);
                    check_field("tardy_total", i_tardy_total, oldest.tardiness);
                    check_field("early_total", i_early_total, oldest.earliness);
                    check_field("jobs_done", i_jobs_done, oldest.jobs);
                end
                checked_total++;
            end
        end
        o_pending <= finished_jobs_q.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import fsse_pkg::*;

    // pipeline depth from the last operation of a job to its result
    localparam int LATENCY         = 3;
    // cycles without any handshake before the run is declared hung
    localparam int HANDSHAKE_LIMIT = 10000;
    localparam int TARGET_REQUESTS = 800;

    // index with no register behind it; writes must be harmless
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = REG_BLOCKING;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_stall;
    logic                  i_cmd          = CMD_OP;
    logic [PROC_W-1:0]     i_proc_time    = '0;
    logic [DUE_W-1:0]      i_due_date     = '0;
    logic                  i_has_due_date = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall    = 1'b0;
    logic [TIME_W-1:0]     o_job_completion;
    logic [TIME_W-1:0]     o_job_idle;
    logic [ACC_W-1:0]      o_total_idle;
    logic [ACC_W-1:0]      o_completion_sum;
    logic [ACC_W-1:0]      o_tardy_total;
    logic [ACC_W-1:0]      o_early_total;
    logic [JOBS_W-1:0]     o_jobs_done;

    int fail_count;
    int jobs_pending;
    int stall_pct     = 0;   // receiver stall odds, updated with NBAs
    int gap_pct       = 0;   // sender idle odds, stimulus process only
    int requests_sent = 0;
    int quiet_cycles  = 0;
    int eff_machines  = 1;   // machines per job under the current setting

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    flow_shop_schedule_evaluator_top i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_cmd             (i_cmd),
        .i_proc_time       (i_proc_time),
        .i_due_date        (i_due_date),
        .i_has_due_date    (i_has_due_date),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_job_completion  (o_job_completion),
        .o_job_idle        (o_job_idle),
        .o_total_idle      (o_total_idle),
        .o_completion_sum  (o_completion_sum),
        .o_tardy_total     (o_tardy_total),
        .o_early_total     (o_early_total),
        .o_jobs_done       (o_jobs_done)
    );

    schedule_checker i_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_cmd             (i_cmd),
        .i_proc_time       (i_proc_time),
        .i_due_date        (i_due_date),
        .i_has_due_date    (i_has_due_date),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_job_completion  (o_job_completion),
        .i_job_idle        (o_job_idle),
        .i_total_idle      (o_total_idle),
        .i_completion_sum  (o_completion_sum),
        .i_tardy_total     (o_tardy_total),
        .i_early_total     (o_early_total),
        .i_jobs_done       (o_jobs_done),
        .o_fail_count      (fail_count),
        .o_pending         (jobs_pending)
    );

    // Result-side back-pressure: a fresh coin every cycle.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: any handshake or register write counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANDSHAKE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", HANDSHAKE_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // 0: no idling, 1: sender mostly idle, 2: receiver mostly stalling, 3: both
    task automatic set_idling(input int mode);
        case (mode)
            1:       begin gap_pct = 85; stall_pct <= 0;  end
            2:       begin gap_pct = 0;  stall_pct <= 85; end
            3:       begin gap_pct = 38; stall_pct <= 38; end
            default: begin gap_pct = 0;  stall_pct <= 0;  end
        endcase
    endtask

    // Present one request and hold it until the block takes it. Valid stays
    // high afterwards so back-to-back requests need no extra edge.
    task automatic send_request(input logic cmd, input logic [PROC_W-1:0] p,
                                input logic [DUE_W-1:0] due, input logic has_due);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= cmd;
        i_proc_time    <= p;
        i_due_date     <= due;
        i_has_due_date <= has_due;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        requests_sent++;
    endtask

    function automatic logic [PROC_W-1:0] pick_proc();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2, 3:    return PROC_W'($urandom_range(0, 15));
            default: return PROC_W'($urandom);
        endcase
    endfunction

    // Due dates near typical completions give both tardy and early jobs.
    function automatic logic [DUE_W-1:0] pick_due();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return DUE_W'($urandom_range(0, 200000));
            default: return DUE_W'($urandom);
        endcase
    endfunction

    task automatic send_op();
        send_request(CMD_OP, pick_proc(), pick_due(), 1'($urandom_range(1)));
    endtask

    // Drop valid, let every owed result come back, then give requests that
    // produce no result time to leave the pipeline.
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (jobs_pending != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Only called with the block idle, right after wait_quiet.
    task automatic configure(input logic [CFG_DATA_W-1:0] blk_data,
                             input logic [CFG_DATA_W-1:0] mach_data,
                             input logic [CFG_DATA_W-1:0] jobs_data);
        int m;
        write_reg(REG_BLOCKING, blk_data);
        write_reg(REG_MACHINES, mach_data);
        write_reg(REG_JOBS, jobs_data);
        if ($urandom_range(3) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
        // machine count is clamped to 1..32 by the block
        m = int'(mach_data[MCNT_W-1:0]);
        if (m < 1) m = 1;
        if (m > DEF_MAX_MACHINES) m = DEF_MAX_MACHINES;
        eff_machines = m;
    endtask

    // One phase: new setting, then mostly whole jobs with random content,
    // plus stray clears, cut-short jobs and sometimes a job left half done
    // so the next setting lands in the middle of a schedule.
    task automatic run_phase(input int phase);
        int                    n_jobs;
        int                    ops;
        logic                  blk;
        logic [MCNT_W-1:0]     m6;
        logic [CFG_DATA_W-1:0] bdata;
        logic [CFG_DATA_W-1:0] mdata;
        logic [CFG_DATA_W-1:0] jdata;
        wait_quiet();
        case (phase)
            // extremes first, out-of-range values clamp
            0: begin blk = 1'b1; m6 = 6'd32; jdata = 11'd1024; end
            1: begin blk = 1'b0; m6 = 6'd32; jdata = 11'd2047; end
            2: begin blk = 1'b1; m6 = 6'd0;  jdata = 11'd0;    end
            3: begin blk = 1'b0; m6 = 6'd63; jdata = 11'd1;    end
            default: begin
                blk = 1'($urandom_range(1));
                case ($urandom_range(9))
                    0:       m6 = 6'd32;
                    1:       m6 = MCNT_W'($urandom_range(0, 63));
                    default: m6 = MCNT_W'($urandom_range(1, 6));
                endcase
                case ($urandom_range(4))
                    0, 1:    jdata = CFG_DATA_W'($urandom_range(1, 12));
                    2:       jdata = 11'd1024;
                    3:       jdata = CFG_DATA_W'($urandom);
                    default: jdata = CFG_DATA_W'($urandom_range(1, 40));
                endcase
            end
        endcase
        // unused upper data bits carry noise
        bdata = CFG_DATA_W'($urandom);
        bdata[0] = blk;
        mdata = CFG_DATA_W'($urandom);
        mdata[MCNT_W-1:0] = m6;
        configure(bdata, mdata, jdata);
        set_idling(phase % 4);

        if ($urandom_range(1)) send_request(CMD_CLEAR, pick_proc(), pick_due(), 1'b1);
        n_jobs = (eff_machines > 8) ? $urandom_range(2, 3) : $urandom_range(3, 12);
        repeat (n_jobs) begin
            ops = ($urandom_range(14) == 0) ? $urandom_range(1, eff_machines) : eff_machines;
            repeat (ops) begin
                if ($urandom_range(24) == 0)
                    send_request(CMD_CLEAR, pick_proc(), pick_due(), 1'($urandom_range(1)));
                else
                    send_op();
            end
        end
        if ($urandom_range(1)) repeat ($urandom_range(0, eff_machines - 1)) send_op();
    endtask

    initial begin
        int phase;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset setting is one machine, so every request is a job.
        set_idling(0);
        send_request(CMD_OP, 16'h0000, 32'h0000_0000, 1'b1);
        send_request(CMD_OP, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);   // early
        send_request(CMD_OP, 16'hFFFF, 32'h0000_0000, 1'b1);   // tardy
        send_request(CMD_OP, 16'h1234, 32'hDEAD_BEEF, 1'b0);   // no due date
        send_request(CMD_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_request(CMD_OP, 16'h0005, 32'h0000_0005, 1'b1);   // exactly on time

        // Blocking, three machines, two jobs: the third job has zero weight.
        wait_quiet();
        configure(11'd1, 11'd3, 11'd2);
        send_request(CMD_OP, 16'd5, 32'd100, 1'b1);
        send_request(CMD_OP, 16'd100, 32'd100, 1'b1);
        send_request(CMD_OP, 16'd5, 32'd100, 1'b1);
        // short first op waits for a busy second machine
        send_request(CMD_OP, 16'd50, 32'd0, 1'b1);
        send_request(CMD_OP, 16'd1, 32'd0, 1'b1);
        send_request(CMD_OP, 16'd1, 32'd0, 1'b0);
        send_request(CMD_OP, 16'd0, 32'hFFFF_FFFF, 1'b1);
        send_request(CMD_OP, 16'd0, 32'hFFFF_FFFF, 1'b1);
        send_request(CMD_OP, 16'd0, 32'hFFFF_FFFF, 1'b1);
        // leave a job two ops in, then shrink to one machine: the pending
        // op index lies past the last machine and closes the job
        send_request(CMD_OP, 16'd7, 32'd0, 1'b1);
        send_request(CMD_OP, 16'd9, 32'd0, 1'b1);
        wait_quiet();
        configure(11'd1, 11'd1, 11'd2);
        send_request(CMD_OP, 16'd3, 32'd50, 1'b1);

        // Random phases cycle through the idling patterns.
        phase = 0;
        while (requests_sent < TARGET_REQUESTS) begin
            run_phase(phase);
            phase++;
        end

        wait_quiet();
        repeat (4 * LATENCY) @(posedge i_clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
